// ===== sv/qalu_pkg.sv =====
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared types, codes and lane sign tables for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qalu_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_MUL = 3'd1,
        OP_DIV = 3'd2,
        OP_MIN = 3'd3,
        OP_MAX = 3'd4
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam int MAGW = 65;
    localparam int QW   = 33;

    localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;

    typedef logic [3:0][31:0] quat_t;

    typedef struct packed {
        op_t              op;
        quat_t            r;
        logic             sat;
        logic [MAGW-1:0]  norm;
    } side_t;

    // term j of lane l pairs element j with element j^l; these bits negate it
    function automatic logic [3:0] neg_mask(input logic [1:0] lane, input logic is_div);
        logic [3:0] m;
        begin
            case (lane)
                2'd0:    m = is_div ? 4'b0000 : 4'b1110;
                2'd1:    m = is_div ? 4'b0110 : 4'b1000;
                2'd2:    m = is_div ? 4'b1100 : 4'b0010;
                default: m = is_div ? 4'b1010 : 4'b0100;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== sv/qalu_lane.sv =====
// ----------------------------------------------------------------------------
// qalu_lane
// One component lane: four products, signed sum, product result and the
// dividend magnitude with an early quotient overflow check.
// ----------------------------------------------------------------------------
module qalu_lane #(
    parameter int FRAC_BITS = 16,
    parameter int LANE      = 0
) (
    input  logic                                   aclk,
    input  logic [3:0]                             en,
    input  qalu_pkg::quat_t                        a,
    input  qalu_pkg::quat_t                        b,
    input  qalu_pkg::op_t                          op,
    input  logic [qalu_pkg::MAGW-1:0]              n_in,
    output logic [31:0]                            mul_val,
    output logic                                   mul_sat,
    output logic [qalu_pkg::MAGW-1:0]              mag,
    output logic [qalu_pkg::MAGW+FRAC_BITS-1:0]    dvd,
    output logic                                   neg,
    output logic                                   ovf
);
    import qalu_pkg::*;

    localparam int DVW  = MAGW + FRAC_BITS;
    localparam int CMPW = DVW + QW;
    localparam logic [1:0] LSEL = LANE[1:0];
    localparam bit NORM = (LANE == 4);

    logic signed [31:0] xs [4];
    logic signed [31:0] ys [4];
    logic signed [63:0] prod_next [4];
    logic signed [63:0] prod_reg [4];
    logic [3:0]         negm_next, negm_reg;
    logic signed [65:0] sum_next, sum_reg;
    logic signed [65:0] sh;
    logic               neg2_reg, neg3_reg, ovf_reg;
    logic [MAGW-1:0]    mag_reg;
    logic [DVW-1:0]     dvd_reg;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (NORM) begin
                xs[j] = $signed(b[j]);
                ys[j] = $signed(b[j]);
            end else if (op == OP_DIV) begin
                xs[j] = $signed(b[j]);
                ys[j] = $signed(a[2'(j) ^ LSEL]);
            end else begin
                xs[j] = $signed(a[j]);
                ys[j] = $signed(b[2'(j) ^ LSEL]);
            end
            prod_next[j] = xs[j] * ys[j];
        end
        negm_next = NORM ? 4'b0000 : neg_mask(LSEL, op == OP_DIV);
    end

    always_comb begin
        sum_next = '0;
        for (int j = 0; j < 4; j++) begin
            if (negm_reg[j]) begin
                sum_next = sum_next - 66'(prod_reg[j]);
            end else begin
                sum_next = sum_next + 66'(prod_reg[j]);
            end
        end
    end

    always_comb begin
        sh      = sum_reg >>> FRAC_BITS;
        mul_sat = (sh[65:31] != {35{sh[31]}});
        if (mul_sat) begin
            mul_val = sh[65] ? VAL_MIN : VAL_MAX;
        end else begin
            mul_val = sh[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg <= prod_next;
            negm_reg <= negm_next;
        end
        if (en[1]) begin
            sum_reg <= sum_next;
        end
        if (en[2]) begin
            neg2_reg <= sum_reg[65];
            mag_reg  <= sum_reg[65] ? MAGW'(-sum_reg) : MAGW'(sum_reg);
        end
        if (en[3]) begin
            neg3_reg <= neg2_reg;
            dvd_reg  <= {mag_reg, {FRAC_BITS{1'b0}}};
            ovf_reg  <= CMPW'({mag_reg, {FRAC_BITS{1'b0}}}) >= CMPW'({n_in, {QW{1'b0}}});
        end
    end

    assign mag = mag_reg;
    assign dvd = dvd_reg;
    assign neg = neg3_reg;
    assign ovf = ovf_reg;

endmodule

// ===== sv/qalu_div_step.sv =====
// ----------------------------------------------------------------------------
// qalu_div_step
// One restoring division stage that settles a single quotient bit.
// ----------------------------------------------------------------------------
module qalu_div_step #(
    parameter int FRAC_BITS = 16,
    parameter int K         = 0
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic [qalu_pkg::MAGW+FRAC_BITS-1:0]    rem_in,
    input  logic [qalu_pkg::QW-1:0]                q_in,
    input  logic                                   neg_in,
    input  logic                                   ovf_in,
    input  logic [qalu_pkg::MAGW-1:0]              n_in,
    output logic [qalu_pkg::MAGW+FRAC_BITS-1:0]    rem_out,
    output logic [qalu_pkg::QW-1:0]                q_out,
    output logic                                   neg_out,
    output logic                                   ovf_out
);
    import qalu_pkg::*;

    localparam int DVW  = MAGW + FRAC_BITS;
    localparam int CMPW = DVW + QW;

    logic [CMPW-1:0] den, diff;
    logic            ge;
    logic [DVW-1:0]  rem_reg;
    logic [QW-1:0]   q_reg;
    logic            neg_reg, ovf_reg;

    always_comb begin
        den  = CMPW'(n_in) << K;
        diff = CMPW'(rem_in) - den;
        ge   = CMPW'(rem_in) >= den;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= ge ? DVW'(diff) : rem_in;
            q_reg   <= q_in | (ge ? (QW'(1) << K) : QW'(0));
            neg_reg <= neg_in;
            ovf_reg <= ovf_in;
        end
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign neg_out = neg_reg;
    assign ovf_out = ovf_reg;

endmodule

// ===== sv/qalu_merge.sv =====
// ----------------------------------------------------------------------------
// qalu_merge
// Combines the lane quotients with the side path into the result and status.
// ----------------------------------------------------------------------------
module qalu_merge (
    input  qalu_pkg::side_t                    sd,
    input  logic [3:0][qalu_pkg::QW-1:0]       q,
    input  logic [3:0]                         neg,
    input  logic [3:0]                         ovf,
    output qalu_pkg::quat_t                    r,
    output logic [1:0]                         status
);
    import qalu_pkg::*;

    quat_t      dv;
    logic [3:0] dsat;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (neg[l]) begin
                dsat[l] = ovf[l] || (q[l] > QW'(33'h0_8000_0000));
                dv[l]   = dsat[l] ? VAL_MIN : 32'(-q[l]);
            end else begin
                dsat[l] = ovf[l] || (q[l][32:31] != 2'b00);
                dv[l]   = dsat[l] ? VAL_MAX : q[l][31:0];
            end
        end
        if (sd.op == OP_DIV) begin
            if (sd.norm == '0) begin
                r      = '0;
                status = ST_DIVZ;
            end else begin
                r      = dv;
                status = (|dsat) ? ST_SAT : ST_OK;
            end
        end else begin
            r      = sd.r;
            status = sd.sat ? ST_SAT : ST_OK;
        end
    end

endmodule

// ===== sv/quaternion_alu_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_alu_unit
// Quaternion add, Hamilton product, divide, minimum and maximum on Q format.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the output is not stalled, and returns
// one result per transaction, in order. The pipeline follows the divide path:
// four lanes (one per component) plus a norm lane form products and sums in
// four stages, then 33 pipelined restoring stages each settle one quotient
// bit, then the result register. Every operation goes through the same
// pipeline, so order is kept. Empty stages close up, so input stalls only
// when all stages hold data and the result is not taken.
module quaternion_alu_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [255:0]   s_tdata,   // a0, a1, a2, a3, b0, b1, b2, b3
    input  logic [2:0]     s_tuser,   // operation
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [127:0]   m_tdata,   // r0, r1, r2, r3
    output logic [1:0]     m_tuser    // status
);
    import qalu_pkg::*;

    localparam int DVW   = MAGW + FRAC_BITS;
    localparam int NDIV  = QW;
    localparam int LAST  = 4 + NDIV;
    localparam int NSTG  = LAST + 1;

    logic [NSTG-1:0]   v_reg;
    logic [NSTG:0]     en;
    side_t             side_reg [LAST];
    side_t             side_next [LAST];
    side_t             side_in;
    quat_t             a, b;
    op_t               op;
    logic signed [32:0] s33;

    logic [3:0][31:0]  mul_val;
    logic [3:0]        mul_sat;
    logic [MAGW-1:0]   norm_mag;
    logic [DVW-1:0]    rem_w [4][NDIV+1];
    logic [QW-1:0]     q_w [4][NDIV+1];
    logic              neg_w [4][NDIV+1];
    logic              ovf_w [4][NDIV+1];
    logic [3:0][QW-1:0] q_fin;
    logic [3:0]        neg_fin, ovf_fin;
    quat_t             r_fin;
    logic [1:0]        st_fin;
    logic [127:0]      m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    assign a  = s_tdata[127:0];
    assign b  = s_tdata[255:128];
    assign op = op_t'(s_tuser);

    always_comb begin
        en[NSTG] = !v_reg[LAST] || m_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];

    always_comb begin
        side_in.op   = op;
        side_in.r    = '0;
        side_in.sat  = 1'b0;
        side_in.norm = '0;
        for (int l = 0; l < 4; l++) begin
            s33 = 33'($signed(a[l])) + 33'($signed(b[l]));
            case (op)
                OP_ADD: begin
                    if (s33[32] != s33[31]) begin
                        side_in.sat  = 1'b1;
                        side_in.r[l] = s33[32] ? VAL_MIN : VAL_MAX;
                    end else begin
                        side_in.r[l] = s33[31:0];
                    end
                end
                OP_MIN:  side_in.r[l] = ($signed(a[l]) < $signed(b[l])) ? a[l] : b[l];
                OP_MAX:  side_in.r[l] = ($signed(a[l]) > $signed(b[l])) ? a[l] : b[l];
                default: side_in.r[l] = '0;
            endcase
        end
    end

    always_comb begin
        side_next[0] = side_in;
        for (int k = 1; k < LAST; k++) begin
            side_next[k] = side_reg[k-1];
        end
        if (side_reg[1].op == OP_MUL) begin
            side_next[2].r   = mul_val;
            side_next[2].sat = |mul_sat;
        end
        side_next[3].norm = norm_mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg[0] <= en[0] ? s_tvalid : v_reg[0];
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < LAST; k++) begin
            if (en[k]) begin
                side_reg[k] <= side_next[k];
            end
        end
        if (en[LAST]) begin
            m_tdata_reg <= r_fin;
            m_tuser_reg <= st_fin;
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        qalu_lane #(.FRAC_BITS(FRAC_BITS), .LANE(l)) u_lane (
            .aclk    (aclk),
            .en      (en[3:0]),
            .a       (a),
            .b       (b),
            .op      (op),
            .n_in    (norm_mag),
            .mul_val (mul_val[l]),
            .mul_sat (mul_sat[l]),
            .mag     (),
            .dvd     (rem_w[l][0]),
            .neg     (neg_w[l][0]),
            .ovf     (ovf_w[l][0])
        );
        assign q_w[l][0] = '0;

        for (genvar s = 0; s < NDIV; s++) begin : g_step
            qalu_div_step #(.FRAC_BITS(FRAC_BITS), .K(NDIV - 1 - s)) u_step (
                .aclk    (aclk),
                .en      (en[4+s]),
                .rem_in  (rem_w[l][s]),
                .q_in    (q_w[l][s]),
                .neg_in  (neg_w[l][s]),
                .ovf_in  (ovf_w[l][s]),
                .n_in    (side_reg[3+s].norm),
                .rem_out (rem_w[l][s+1]),
                .q_out   (q_w[l][s+1]),
                .neg_out (neg_w[l][s+1]),
                .ovf_out (ovf_w[l][s+1])
            );
        end

        assign q_fin[l]   = q_w[l][NDIV];
        assign neg_fin[l] = neg_w[l][NDIV];
        assign ovf_fin[l] = ovf_w[l][NDIV];
    end

    qalu_lane #(.FRAC_BITS(FRAC_BITS), .LANE(4)) u_norm (
        .aclk    (aclk),
        .en      (en[3:0]),
        .a       (a),
        .b       (b),
        .op      (op),
        .n_in    (norm_mag),
        .mul_val (),
        .mul_sat (),
        .mag     (norm_mag),
        .dvd     (),
        .neg     (),
        .ovf     ()
    );

    qalu_merge u_merge (
        .sd     (side_reg[LAST-1]),
        .q      (q_fin),
        .neg    (neg_fin),
        .ovf    (ovf_fin),
        .r      (r_fin),
        .status (st_fin)
    );

    assign m_tvalid = v_reg[LAST];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_divz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_DIVZ) |-> (m_tdata == '0))
        else $error("zero norm result not cleared");

    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
